@@ rtl/arp_pkg.sv @@
// arp_pkg: shared constants, types and helpers for the attitude rate controller
// used by arp_div, attitude_rate_pid and arp_checker; no dependencies
package arp_pkg;

    localparam int IN_W  = 280;
    localparam int OUT_W = 112;

    localparam int OFS_TARGET   = 0;
    localparam int OFS_MEASURED = 57;
    localparam int OFS_GYRO     = 114;
    localparam int OFS_DT       = 210;
    localparam int OFS_THR      = 226;
    localparam int OFS_ADJ      = 243;
    localparam int ANGLE_W      = 19;

    localparam logic signed [19:0] PI_Q        = 20'sd205887;
    localparam logic signed [19:0] NEG_PI_Q    = -20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q    = 20'sd411775;
    localparam logic signed [19:0] ANGLE_LIM_Q = 20'sd51472;
    localparam logic signed [19:0] NEG_LIM_Q   = -20'sd51472;

    localparam logic [23:0] W_P_Q          = 24'd12353342;
    localparam logic [23:0] W_D_Q          = 24'd6176671;
    localparam logic [16:0] THROTTLE_MIN_Q = 17'd3276;
    localparam logic signed [33:0] THRUST_MAX_Q = 34'sd52429;

    localparam logic signed [49:0] INTEGRAL_LIMIT     = 50'sd32768;
    localparam logic signed [49:0] NEG_INTEGRAL_LIMIT = -50'sd32768;

    localparam logic [2:0] G_ANGLE_TILT = 3'd0;
    localparam logic [2:0] G_ANGLE_YAW  = 3'd1;
    localparam logic [2:0] G_P_TILT     = 3'd2;
    localparam logic [2:0] G_P_YAW      = 3'd3;
    localparam logic [2:0] G_I_TILT     = 3'd4;
    localparam logic [2:0] G_I_YAW      = 3'd5;
    localparam logic [2:0] G_D_TILT     = 3'd6;
    localparam logic [2:0] G_D_YAW      = 3'd7;

    localparam logic [31:0] GAIN_RESET [8] = '{
        32'd184549376, 32'd268435456, 32'd201327, 32'd1845494,
        32'd50332, 32'd167772, 32'd21810, 32'd134218
    };

    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_Q_W   = 31;

    localparam logic [4:0] DIV_K_ALPHA = 5'd17;
    localparam logic [4:0] DIV_K_DERIV = 5'd31;

    typedef struct packed {
        logic                 start;
        logic [4:0]           k;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/arp_mul.sv @@
// arp_mul: shared signed 33 x 33 multiplier with registered product
// depends on nothing but the clock
module arp_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ rtl/arp_div.sv @@
// arp_div: restoring unsigned divider, one quotient bit per cycle
// depends on arp_pkg for the request and response types
module arp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  arp_pkg::div_req_t   req,
    output arp_pkg::div_rsp_t   rsp
);
    import arp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [31:0]          low_reg;
    logic [DIV_Q_W-1:0]   q_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;
    logic [DIV_NUM_W-1:0] num_sh;

    always_comb
    begin
        trial   = {rem_reg, low_reg[cnt_reg]};
        ge      = trial >= {1'b0, den_reg};
        rem_sub = ge ? trial - {1'b0, den_reg} : trial;
        num_sh  = req.num >> req.k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.k - 5'd1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= num_sh[DIV_DEN_W-1:0];
            den_reg <= req.den;
            low_reg <= req.num[31:0];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_sub[DIV_DEN_W-1:0];
            q_reg   <= {q_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

@@ rtl/attitude_rate_pid.sv @@
// attitude_rate_pid: top level, sequencer and per-axis state of the cascaded controller
// depends on arp_pkg, arp_mul and arp_div
//
// One sample is taken at a time: after a beat is accepted the block is not ready until it
// has run two 17-bit divisions for the filter coefficients, then per axis the error, filter,
// integral and moment steps on the shared multiplier plus a 31-bit division for the
// derivative, and has loaded the result. The derivative division is skipped when the step
// time is zero or the quotient saturates; at low throttle the moment steps are skipped. The
// result waits in an output register, so the next sample can be accepted while it is not yet
// taken; a result still waiting when the next one is done holds the block in its last step.
// Gains are to be written by the user through the configuration port only while no sample
// is in flight; the block itself does not enforce this.
module attitude_rate_pid (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // target_roll, target_pitch, target_yaw, measured_roll, measured_pitch,
    // measured_yaw, gyro_roll_rate, gyro_pitch_rate, gyro_yaw_rate, step_time,
    // throttle_command, thrust_adjust, zero fill
    input  logic [arp_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // moment_roll, moment_pitch, moment_yaw, thrust_out
    output logic [arp_pkg::OUT_W-1:0] m_tdata,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_addr,
    input  logic [31:0]              cfg_data
);
    import arp_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_A_MUL  = 5'd1;
    localparam logic [4:0] S_A_DIV  = 5'd2;
    localparam logic [4:0] S_A_WAIT = 5'd3;
    localparam logic [4:0] S_E_MUL  = 5'd4;
    localparam logic [4:0] S_E_FIN  = 5'd5;
    localparam logic [4:0] S_P_MUL  = 5'd6;
    localparam logic [4:0] S_P_FIN  = 5'd7;
    localparam logic [4:0] S_D_DIV  = 5'd8;
    localparam logic [4:0] S_D_WAIT = 5'd9;
    localparam logic [4:0] S_DL_MUL = 5'd10;
    localparam logic [4:0] S_DL_FIN = 5'd11;
    localparam logic [4:0] S_I_MUL  = 5'd12;
    localparam logic [4:0] S_I_FIN  = 5'd13;
    localparam logic [4:0] S_M_KP   = 5'd14;
    localparam logic [4:0] S_M_KI   = 5'd15;
    localparam logic [4:0] S_M_KD   = 5'd16;
    localparam logic [4:0] S_M_FIN  = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0]         state_reg, state_next;
    logic [1:0]         axis_reg;
    logic               sel_reg;
    logic [IN_W-1:0]    item_reg;
    logic [15:0]        alpha_p_reg, alpha_d_reg;
    logic signed [31:0] e_reg, din_reg;
    logic               neg_reg;
    logic signed [65:0] sum_reg;
    logic signed [31:0] fp_reg [3];
    logic signed [31:0] fd_reg [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] integ_reg [3];
    logic signed [31:0] mom_reg [3];
    logic [OUT_W-1:0]   out_reg;
    logic               out_valid_reg;
    logic [31:0]        gain_reg [8];

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    div_req_t           dreq;
    div_rsp_t           drsp;

    logic               is_yaw;
    logic signed [18:0] tsel, msel;
    logic signed [31:0] gyro, fp, fd, prev, integ;
    logic [15:0]        dt;
    logic [16:0]        thr;
    logic signed [31:0] adj;
    logic               active;
    logic [31:0]        ka, kp, ki, kd;
    logic signed [19:0] errw, errr, errc;
    logic [23:0]        wdt;
    logic signed [65:0] e_rnd, h_rnd, m_tot, m_rnd;
    logic signed [41:0] e_sh, m_sh;
    logic signed [31:0] e_val, mom_val;
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [DIV_NUM_W-1:0] dnum;
    logic               dsat;
    logic signed [31:0] din_q;
    logic signed [49:0] i_acc;
    logic signed [31:0] i_new;
    logic signed [33:0] thr_sum;
    logic [15:0]        thrust;

    arp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    arp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        is_yaw = axis_reg == 2'd2;
        tsel   = item_reg[OFS_TARGET + ANGLE_W*axis_reg +: ANGLE_W];
        msel   = item_reg[OFS_MEASURED + ANGLE_W*axis_reg +: ANGLE_W];
        gyro   = item_reg[OFS_GYRO + 32*axis_reg +: 32];
        dt     = item_reg[OFS_DT +: 16];
        thr    = item_reg[OFS_THR +: 17];
        adj    = item_reg[OFS_ADJ +: 32];
        active = thr > THROTTLE_MIN_Q;
        fp     = fp_reg[axis_reg];
        fd     = fd_reg[axis_reg];
        prev   = prev_reg[axis_reg];
        integ  = integ_reg[axis_reg];
        ka     = gain_reg[is_yaw ? G_ANGLE_YAW : G_ANGLE_TILT];
        kp     = gain_reg[is_yaw ? G_P_YAW : G_P_TILT];
        ki     = gain_reg[is_yaw ? G_I_YAW : G_I_TILT];
        kd     = gain_reg[is_yaw ? G_D_YAW : G_D_TILT];

        // angle error wrap and clamp
        errw = {tsel[18], tsel} - {msel[18], msel};
        if (errw > PI_Q)
            errr = errw - TWO_PI_Q;
        else if (errw < NEG_PI_Q)
            errr = errw + TWO_PI_Q;
        else
            errr = errw;
        if (errr > ANGLE_LIM_Q)
            errc = ANGLE_LIM_Q;
        else if (errr < NEG_LIM_Q)
            errc = NEG_LIM_Q;
        else
            errc = errr;

        wdt   = mul_p[39:16];

        e_rnd = mul_p + 66'sd8388608;
        e_sh  = e_rnd[65:24];
        e_val = sat32({{26{e_sh[41]}}, e_sh} - {{36{gyro[31]}}, gyro});

        h_rnd = mul_p + 66'sd32768;

        diff  = {e_reg[31], e_reg} - {prev[31], prev};
        mag   = diff[32] ? 33'(-diff) : 33'(diff);
        dnum  = {mag, 16'd0};
        dsat  = dnum[48:31] >= {2'd0, dt};
        din_q = neg_reg ? -$signed({1'b0, drsp.quot}) : $signed({1'b0, drsp.quot});

        i_acc = $signed(h_rnd[65:16]) + {{18{integ[31]}}, integ};
        if (i_acc > INTEGRAL_LIMIT)
            i_new = 32'(INTEGRAL_LIMIT);
        else if (i_acc < NEG_INTEGRAL_LIMIT)
            i_new = 32'(NEG_INTEGRAL_LIMIT);
        else
            i_new = i_acc[31:0];

        m_tot   = sum_reg + mul_p;
        m_rnd   = m_tot + 66'sd8388608;
        m_sh    = m_rnd[65:24];
        mom_val = sat32({{26{m_sh[41]}}, m_sh});

        thr_sum = {17'd0, thr} + {{2{adj[31]}}, adj};
        if (thr_sum < 34'sd0)
            thrust = '0;
        else if (thr_sum > THRUST_MAX_Q)
            thrust = THRUST_MAX_Q[15:0];
        else
            thrust = thr_sum[15:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_A_MUL:
            begin
                mul_a = {9'd0, sel_reg ? W_D_Q : W_P_Q};
                mul_b = {17'd0, dt};
            end
            S_E_MUL:
            begin
                mul_a = {1'b0, ka};
                mul_b = {{16{errc[16]}}, errc[16:0]};
            end
            S_P_MUL:
            begin
                mul_a = {17'd0, alpha_p_reg};
                mul_b = {e_reg[31], e_reg} - {fp[31], fp};
            end
            S_DL_MUL:
            begin
                mul_a = {17'd0, alpha_d_reg};
                mul_b = {din_reg[31], din_reg} - {fd[31], fd};
            end
            S_I_MUL:
            begin
                mul_a = {17'd0, dt};
                mul_b = {e_reg[31], e_reg};
            end
            S_M_KP:
            begin
                mul_a = {1'b0, kp};
                mul_b = {fp[31], fp};
            end
            S_M_KI:
            begin
                mul_a = {1'b0, ki};
                mul_b = {integ[31], integ};
            end
            S_M_KD:
            begin
                mul_a = {1'b0, kd};
                mul_b = {fd[31], fd};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.k     = DIV_K_ALPHA;
        dreq.num   = {9'd0, wdt, 16'd0};
        dreq.den   = 25'd65536 + {1'b0, wdt};
        if (state_reg == S_A_DIV)
        begin
            dreq.start = 1'b1;
        end
        else if (state_reg == S_D_DIV)
        begin
            dreq.start = (dt != 16'd0) && !dsat;
            dreq.k     = DIV_K_DERIV;
            dreq.num   = dnum;
            dreq.den   = {9'd0, dt};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_A_MUL;
            S_A_MUL:  state_next = S_A_DIV;
            S_A_DIV:  state_next = S_A_WAIT;
            S_A_WAIT: if (drsp.done) state_next = sel_reg ? S_E_MUL : S_A_MUL;
            S_E_MUL:  state_next = S_E_FIN;
            S_E_FIN:  state_next = S_P_MUL;
            S_P_MUL:  state_next = S_P_FIN;
            S_P_FIN:  state_next = S_D_DIV;
            S_D_DIV:  state_next = dreq.start ? S_D_WAIT : S_DL_MUL;
            S_D_WAIT: if (drsp.done) state_next = S_DL_MUL;
            S_DL_MUL: state_next = S_DL_FIN;
            S_DL_FIN: state_next = S_I_MUL;
            S_I_MUL:  state_next = S_I_FIN;
            S_I_FIN:
            begin
                if (active)
                    state_next = S_M_KP;
                else
                    state_next = is_yaw ? S_DONE : S_E_MUL;
            end
            S_M_KP:   state_next = S_M_KI;
            S_M_KI:   state_next = S_M_KD;
            S_M_KD:   state_next = S_M_FIN;
            S_M_FIN:  state_next = is_yaw ? S_DONE : S_E_MUL;
            S_DONE:   if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                fp_reg[i]    <= '0;
                fd_reg[i]    <= '0;
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                gain_reg[i] <= GAIN_RESET[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                gain_reg[cfg_addr] <= cfg_data;
            if (out_valid_reg && m_tready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    sel_reg  <= 1'b0;
                    axis_reg <= '0;
                end
                S_A_WAIT:
                begin
                    if (drsp.done)
                    begin
                        sel_reg <= 1'b1;
                        if (sel_reg)
                            alpha_d_reg <= drsp.quot[15:0];
                        else
                            alpha_p_reg <= drsp.quot[15:0];
                    end
                end
                S_E_FIN:  e_reg <= e_val;
                S_P_FIN:  fp_reg[axis_reg] <= fp + h_rnd[47:16];
                S_D_DIV:
                begin
                    neg_reg <= diff[32];
                    if (dt == 16'd0)
                        din_reg <= '0;
                    else if (dsat)
                        din_reg <= diff[32] ? 32'sh80000000 : 32'sh7fffffff;
                end
                S_D_WAIT: if (drsp.done) din_reg <= din_q;
                S_DL_FIN:
                begin
                    fd_reg[axis_reg]   <= fd + h_rnd[47:16];
                    prev_reg[axis_reg] <= e_reg;
                end
                S_I_FIN:
                begin
                    integ_reg[axis_reg] <= active ? i_new : 32'sd0;
                    if (!active)
                    begin
                        mom_reg[axis_reg] <= '0;
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                S_M_KI:   sum_reg <= mul_p;
                S_M_KD:   sum_reg <= sum_reg + mul_p;
                S_M_FIN:
                begin
                    mom_reg[axis_reg] <= mom_val;
                    axis_reg <= axis_reg + 2'd1;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= {thrust, mom_reg[2], mom_reg[1], mom_reg[0]};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
            item_reg <= s_tdata;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

@@ rtl/arp_checker.sv @@
// arp_checker: port-level assertions for attitude_rate_pid, bound to the top level
// depends on arp_pkg for the stream widths
module arp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [arp_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [arp_pkg::OUT_W-1:0] m_tdata,
    input logic                      cfg_we,
    input logic [2:0]                cfg_addr,
    input logic [31:0]               cfg_data
);
    import arp_pkg::*;

    logic in_beat;
    assign in_beat = s_tvalid && s_tready;

    // thrust stays within its clamp
    a_thrust_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[111:96] <= THRUST_MAX_Q[15:0])
        else $error("thrust out of range");

    // one sample in flight at a time
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("ready right after accepted beat");

    // no result right on the heels of an input beat
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(in_beat))
        else $error("result appeared too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // gain writes only while idle and with known index and data
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> s_tready && !s_tvalid && !$isunknown({cfg_addr, cfg_data}))
        else $error("gain write while busy");

endmodule

bind attitude_rate_pid arp_checker u_arp_checker (.*);
